[src/tpcd_pkg.sv]
// Shared constants, command codes and the volume table of the pattern cell decoder.
package tpcd_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [7:0] NO_EFFECT     = 8'hFF;
	localparam logic [7:0] NO_NOTE_LIMIT = 8'hFE;
	localparam logic [7:0] KEEP_ZERO_FX  = 8'h30;
	localparam logic [6:0] NOTE_BASE     = 7'd37;
	localparam logic [7:0] FREQ_ADJ_BIT  = 8'h20;
	localparam logic [7:0] PAN_LEFT      = 8'h4F;
	localparam logic [7:0] PAN_RIGHT     = 8'hF4;

	// raw effect nibbles that need fix-ups
	localparam logic [3:0] FX_FREQ_ADJ  = 4'd3;
	localparam logic [3:0] FX_VIBRATO   = 4'd4;
	localparam logic [3:0] FX_SPEED     = 4'd5;
	localparam logic [3:0] FX_PAN_SLIDE = 4'd6;

	// dense output command codes
	localparam logic [3:0] CMD_NOP        = 4'd0;
	localparam logic [3:0] CMD_SLIDE_UP   = 4'd1;
	localparam logic [3:0] CMD_SLIDE_DOWN = 4'd2;
	localparam logic [3:0] CMD_TONE_SLIDE = 4'd3;
	localparam logic [3:0] CMD_EXTENDED   = 4'd4;
	localparam logic [3:0] CMD_VIB        = 4'd5;
	localparam logic [3:0] CMD_TEMPO      = 4'd6;
	localparam logic [3:0] CMD_PAN_SLIDE  = 4'd7;
	localparam logic [3:0] CMD_RETRIGGER  = 4'd8;

	// (v*64+8)/15 for a 4-bit volume
	function automatic logic [6:0] scale_volume(input logic [3:0] v);
		logic [6:0] r;
		case (v)
			4'd0:    r = 7'd0;
			4'd1:    r = 7'd4;
			4'd2:    r = 7'd9;
			4'd3:    r = 7'd13;
			4'd4:    r = 7'd17;
			4'd5:    r = 7'd21;
			4'd6:    r = 7'd26;
			4'd7:    r = 7'd30;
			4'd8:    r = 7'd34;
			4'd9:    r = 7'd38;
			4'd10:   r = 7'd43;
			4'd11:   r = 7'd47;
			4'd12:   r = 7'd51;
			4'd13:   r = 7'd56;
			4'd14:   r = 7'd60;
			4'd15:   r = 7'd64;
			default: r = 7'd0;
		endcase
		return r;
	endfunction

endpackage

[src/tracker_pattern_cell_decoder.sv]
// Pattern cell decoder: input register, cell decode with per-channel effect memory, result register.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   in      | in_valid / in_stall  | pattern_start, channel, byte0, byte1, byte2
//   out     | out_valid/ out_stall | note_valid, note_out, instrument_out,
//           |                      | volume_valid, volume_out, command_out, param_out
//
// One item per cycle while not stalled; items pass the input register, then the result register.
// The effect memory is a row of flip-flops, read and written back in the decode stage,
// so a following item in the same channel sees the update without extra delay.
// Reset sets every effect memory entry to 0xFF (no effect) and empties both stages.
// in_stall rises only when the input register is full and the result is held by out_stall.
module tracker_pattern_cell_decoder
	import tpcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       pattern_start,
	input  logic [2:0] channel,
	input  logic [7:0] byte0,
	input  logic [7:0] byte1,
	input  logic [7:0] byte2,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       note_valid,
	output logic [6:0] note_out,
	output logic [6:0] instrument_out,
	output logic       volume_valid,
	output logic [6:0] volume_out,
	output logic [3:0] command_out,
	output logic [7:0] param_out
);

	logic       valid_s1;
	logic       start_s1;
	logic [2:0] chn_s1;
	logic [7:0] b0_s1;
	logic [7:0] b1_s1;
	logic [7:0] b2_s1;

	logic [7:0] fx_mem_q [CHANNELS];
	logic       out_valid_q;

	logic                advance;
	logic                in_range;
	logic [CH_IDX_W-1:0] idx;
	logic [7:0]          mem_rd;
	logic [7:0]          mem_nx;
	logic                has_note;
	logic                has_vol;
	logic [6:0]          note_c;
	logic [6:0]          instr_c;
	logic [6:0]          vol_c;
	logic [3:0]          cmd_c;
	logic [7:0]          param_c;
	logic [3:0]          eff;
	logic [3:0]          prm;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_s1 <= pattern_start;
			chn_s1   <= channel;
			b0_s1    <= byte0;
			b1_s1    <= byte1;
			b2_s1    <= byte2;
		end
	end

	// decode
	always_comb begin
		in_range = 32'(chn_s1) < CHANNELS;
		idx      = CH_IDX_W'(chn_s1);
		mem_rd   = (start_s1 || !in_range) ? NO_EFFECT : fx_mem_q[idx];
		has_note = b0_s1 < NO_NOTE_LIMIT;
		has_vol  = b0_s1 <= NO_NOTE_LIMIT;

		note_c  = 7'd0;
		instr_c = 7'd0;
		vol_c   = 7'd0;
		mem_nx  = mem_rd;
		if (has_note) begin
			note_c  = 7'(b0_s1[7:2]) + NOTE_BASE;
			instr_c = {1'b0, b0_s1[1:0], b1_s1[7:4]} + 7'd1;
			mem_nx  = NO_EFFECT;
		end
		if (has_vol) begin
			vol_c = scale_volume(b1_s1[3:0]);
		end

		if (b2_s1 != NO_EFFECT) begin
			mem_nx = b2_s1;
		end
		// a zero parameter drops the memory, except for the frequency-adjust byte with zero
		if (b2_s1[3:0] == 4'd0 && b2_s1 != KEEP_ZERO_FX) begin
			mem_nx = NO_EFFECT;
		end

		eff     = mem_nx[7:4];
		prm     = mem_nx[3:0];
		cmd_c   = CMD_NOP;
		param_c = 8'd0;
		if (mem_nx != NO_EFFECT && !eff[3]) begin
			cmd_c   = eff + 4'd1;
			param_c = {4'd0, prm};
			case (eff)
				FX_FREQ_ADJ: begin
					param_c = param_c | FREQ_ADJ_BIT;
					mem_nx  = NO_EFFECT;
				end
				FX_VIBRATO: begin
					param_c = {prm, prm};
				end
				FX_SPEED: begin
					mem_nx = NO_EFFECT;
				end
				FX_PAN_SLIDE: begin
					if (prm == 4'd0) begin
						param_c = PAN_LEFT;
					end else if (prm == 4'd1) begin
						param_c = PAN_RIGHT;
					end else begin
						cmd_c   = CMD_NOP;
						param_c = 8'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// effect memory: clear all on pattern start, then write back this channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				fx_mem_q[i] <= NO_EFFECT;
			end
		end else if (valid_s1 && advance) begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (in_range && idx == CH_IDX_W'(i)) begin
					fx_mem_q[i] <= mem_nx;
				end else if (start_s1) begin
					fx_mem_q[i] <= NO_EFFECT;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			note_valid     <= has_note;
			note_out       <= note_c;
			instrument_out <= instr_c;
			volume_valid   <= has_vol;
			volume_out     <= vol_c;
			command_out    <= cmd_c;
			param_out      <= param_c;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while the pipeline could move");

	a_none_has_zero_param: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && command_out == CMD_NOP) |-> (param_out == 8'd0))
		else $error("parameter set without a command");

	a_note_implies_volume: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && note_valid) |-> volume_valid)
		else $error("note without volume");

	a_no_note_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !note_valid) |-> (note_out == 7'd0 && instrument_out == 7'd0))
		else $error("note fields set without a note");

	a_pan_param: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && command_out == CMD_PAN_SLIDE) |->
		(param_out == PAN_LEFT || param_out == PAN_RIGHT))
		else $error("pan slide with a bad parameter");
`endif

endmodule

[dv/tb.sv]
// Self-checking testbench for the tracker pattern cell decoder.
module tb
	import tpcd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       nv;
		logic [6:0] note;
		logic [6:0] instr;
		logic       vv;
		logic [6:0] vol;
		logic [3:0] cmd;
		logic [7:0] par;
	} cell_result_t;

	typedef struct packed {
		logic         start;
		logic [2:0]   ch;
		logic [7:0]   b0;
		logic [7:0]   b1;
		logic [7:0]   b2;
		logic         typed;
		cell_result_t want;
	} cell_row_t;

	localparam int DIR_ROWS = 27;
	localparam int RAND_PER_PHASE = 484;
	localparam int MAX_REPORTS = 20;

	// typed rows carry their expected result, the rest go through the predictor
	localparam cell_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
		'{1'b0, 3'd0, 8'hFF, 8'h00, 8'hFF, 1'b1, '{1'b0, 7'd0, 7'd0, 1'b0, 7'd0, CMD_NOP, 8'h00}},
		'{1'b0, 3'd0, 8'h00, 8'h00, 8'hFF, 1'b1, '{1'b1, 7'd37, 7'd1, 1'b1, 7'd0, CMD_NOP, 8'h00}},
		'{1'b0, 3'd1, 8'hFD, 8'hFF, 8'hFF, 1'b1,
			'{1'b1, 7'd100, 7'd32, 1'b1, 7'd64, CMD_NOP, 8'h00}},
		'{1'b0, 3'd2, 8'hFE, 8'h0F, 8'hFF, 1'b1, '{1'b0, 7'd0, 7'd0, 1'b1, 7'd64, CMD_NOP, 8'h00}},
		'{1'b0, 3'd3, 8'hFF, 8'h00, 8'h05, 1'b1,
			'{1'b0, 7'd0, 7'd0, 1'b0, 7'd0, CMD_SLIDE_UP, 8'h05}},
		'{1'b0, 3'd3, 8'hFF, 8'h00, 8'hFF, 1'b0, '0},
		'{1'b0, 3'd3, 8'hFF, 8'h00, 8'h10, 1'b0, '0},
		'{1'b0, 3'd3, 8'hFF, 8'h00, 8'hFF, 1'b0, '0},
		'{1'b0, 3'd4, 8'h7B, 8'hA5, 8'h1A, 1'b0, '0},
		'{1'b0, 3'd4, 8'hFF, 8'h00, 8'h2F, 1'b0, '0},
		'{1'b0, 3'd4, 8'hFF, 8'h00, 8'h37, 1'b0, '0},
		'{1'b0, 3'd4, 8'hFF, 8'h00, 8'hFF, 1'b0, '0},
		'{1'b0, 3'd4, 8'hFF, 8'h00, 8'h30, 1'b0, '0},
		'{1'b0, 3'd5, 8'hFE, 8'h08, 8'h4C, 1'b0, '0},
		'{1'b0, 3'd5, 8'hFF, 8'h00, 8'h53, 1'b0, '0},
		'{1'b0, 3'd5, 8'hFF, 8'h00, 8'hFF, 1'b0, '0},
		'{1'b0, 3'd6, 8'hFF, 8'h00, 8'h60, 1'b0, '0},
		'{1'b0, 3'd6, 8'hFF, 8'h00, 8'h61, 1'b1,
			'{1'b0, 7'd0, 7'd0, 1'b0, 7'd0, CMD_PAN_SLIDE, PAN_RIGHT}},
		'{1'b0, 3'd6, 8'hFF, 8'h00, 8'h62, 1'b1, '{1'b0, 7'd0, 7'd0, 1'b0, 7'd0, CMD_NOP, 8'h00}},
		'{1'b0, 3'd6, 8'h85, 8'h3C, 8'h7E, 1'b0, '0},
		'{1'b0, 3'd7, 8'hFF, 8'h00, 8'h85, 1'b0, '0},
		'{1'b0, 3'd7, 8'hFF, 8'h00, 8'hF1, 1'b0, '0},
		'{1'b0, 3'd7, 8'h40, 8'h5A, 8'hFF, 1'b0, '0},
		'{1'b0, 3'd0, 8'hFF, 8'h00, 8'h23, 1'b0, '0},
		'{1'b0, 3'd1, 8'hFF, 8'h00, 8'h45, 1'b0, '0},
		'{1'b1, 3'd0, 8'hFF, 8'h00, 8'hFF, 1'b0, '0},
		'{1'b0, 3'd1, 8'hFF, 8'h00, 8'hFF, 1'b0, '0}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       pattern_start;
	logic [2:0] channel;
	logic [7:0] byte0;
	logic [7:0] byte1;
	logic [7:0] byte2;
	logic       out_valid;
	logic       out_stall;
	logic       note_valid;
	logic [6:0] note_out;
	logic [6:0] instrument_out;
	logic       volume_valid;
	logic [6:0] volume_out;
	logic [3:0] command_out;
	logic [7:0] param_out;

	logic [7:0]   fx_mem [0:CHANNELS-1];
	cell_result_t cell_q [$];
	int           tx_idle_pct;
	int           rx_idle_pct;
	int           errors;
	int           reports;
	int           n_cells;
	int           n_notes;
	int           n_cmds;
	int           n_starts;

	tracker_pattern_cell_decoder DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pattern_start  (pattern_start),
		.channel        (channel),
		.byte0          (byte0),
		.byte1          (byte1),
		.byte2          (byte2),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.note_valid     (note_valid),
		.note_out       (note_out),
		.instrument_out (instrument_out),
		.volume_valid   (volume_valid),
		.volume_out     (volume_out),
		.command_out    (command_out),
		.param_out      (param_out)
	);

	// decode one cell and update the channel effect memory
	function automatic cell_result_t decode_cell(input logic st, input logic [2:0] ch,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		cell_result_t r;
		logic [7:0]   fx;
		logic [3:0]   eff;
		logic [3:0]   prm;
		int           v;
		r = '0;
		r.cmd = CMD_NOP;
		if (st) begin
			for (int i = 0; i < CHANNELS; i++)
				fx_mem[i] = NO_EFFECT;
		end
		fx = (int'(ch) < CHANNELS) ? fx_mem[ch] : NO_EFFECT;
		if (b0 < NO_NOTE_LIMIT) begin
			r.nv = 1'b1;
			r.note = 7'(int'(b0[7:2]) + 37);
			r.instr = 7'(int'({b0[1:0], b1[7:4]}) + 1);
			fx = NO_EFFECT;
		end
		if (b0 <= NO_NOTE_LIMIT) begin
			v = int'(b1[3:0]);
			r.vv = 1'b1;
			r.vol = 7'((v * 64 + 8) / 15);
		end
		if (b2 != NO_EFFECT)
			fx = b2;
		if (b2[3:0] == 4'd0 && b2 != KEEP_ZERO_FX)
			fx = NO_EFFECT;
		if (fx != NO_EFFECT && !fx[7]) begin
			eff = fx[7:4];
			prm = fx[3:0];
			r.cmd = eff + 4'd1;
			r.par = {4'd0, prm};
			case (eff)
				FX_FREQ_ADJ: begin
					r.par = r.par | FREQ_ADJ_BIT;
					fx = NO_EFFECT;
				end
				FX_VIBRATO: r.par = {prm, prm};
				FX_SPEED: fx = NO_EFFECT;
				FX_PAN_SLIDE: begin
					if (prm == 4'd0)
						r.par = PAN_LEFT;
					else if (prm == 4'd1)
						r.par = PAN_RIGHT;
					else begin
						r.cmd = CMD_NOP;
						r.par = 8'h00;
					end
				end
				default: ;
			endcase
		end
		if (int'(ch) < CHANNELS)
			fx_mem[ch] = fx;
		return r;
	endfunction

	task automatic send_cell(input logic st, input logic [2:0] ch, input logic [7:0] b0,
			input logic [7:0] b1, input logic [7:0] b2, input logic typed,
			input cell_result_t want);
		cell_result_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		pattern_start = st;
		channel = ch;
		byte0 = b0;
		byte1 = b1;
		byte2 = b2;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = decode_cell(st, ch, b0, b1, b2);
		if (typed)
			r = want;
		cell_q.push_back(r);
		n_cells++;
		if (st)
			n_starts++;
		if (r.nv)
			n_notes++;
		if (r.cmd != CMD_NOP)
			n_cmds++;
		@(negedge clk);
	endtask

	// random cells, many of them with an effect byte, and effect-free cells between them so memory carries across rows
	task automatic send_random_cell();
		logic       st;
		logic [2:0] ch;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		int         r;
		st = ($urandom_range(99) < 3);
		ch = 3'($urandom_range(7));
		r = $urandom_range(99);
		b0 = (r < 30) ? NO_EFFECT : (r < 45) ? NO_NOTE_LIMIT : 8'($urandom_range(253));
		b1 = 8'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 40)
			b2 = NO_EFFECT;
		else if (r < 43)
			b2 = KEEP_ZERO_FX;
		else if (r < 85)
			b2 = {4'($urandom_range(7)), 4'($urandom_range(15))};
		else
			b2 = 8'($urandom_range(255));
		send_cell(st, ch, b0, b1, b2, 1'b0, '0);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			if (reports < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			reports++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(2_000_000);
		$display("FAIL");
		$finish;
	end

	// receiver: stall at random at the falling edge
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		cell_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (cell_q.size() == 0) begin
				errors++;
				$display("%0t: result with no cell pending, actual cmd %0d param %0h",
					$time, command_out, param_out);
			end else begin
				want = cell_q.pop_front();
				check_field("note_valid", want.nv, note_valid);
				check_field("note_out", want.note, note_out);
				check_field("instrument_out", want.instr, instrument_out);
				check_field("volume_valid", want.vv, volume_valid);
				check_field("volume_out", want.vol, volume_out);
				check_field("command_out", want.cmd, command_out);
				check_field("param_out", want.par, param_out);
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		pattern_start = 1'b0;
		channel = 3'd0;
		byte0 = 8'h00;
		byte1 = 8'h00;
		byte2 = 8'h00;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		errors = 0;
		reports = 0;
		n_cells = 0;
		n_notes = 0;
		n_cmds = 0;
		n_starts = 0;
		for (int i = 0; i < CHANNELS; i++)
			fx_mem[i] = NO_EFFECT;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 86 : 0;
			rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 33 : 0;
			if (ph == 0) begin
				foreach (DIR_TABLE[i])
					send_cell(DIR_TABLE[i].start, DIR_TABLE[i].ch, DIR_TABLE[i].b0,
						DIR_TABLE[i].b1, DIR_TABLE[i].b2, DIR_TABLE[i].typed,
						DIR_TABLE[i].want);
			end
			for (int i = 0; i < RAND_PER_PHASE; i++)
				send_random_cell();
		end
		in_valid = 1'b0;

		while (cell_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (cell_q.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, cell_q.size());
		end
		if (reports > MAX_REPORTS)
			$display("%0d further field mismatches not shown", reports - MAX_REPORTS);
		$display("Decoded %0d cells under three pacing phases: %0d with a note,", n_cells, n_notes);
		$display("%0d with an effect command, %0d pattern starts; %0d errors.",
			n_cmds, n_starts, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
src/tpcd_pkg.sv
src/tracker_pattern_cell_decoder.sv
dv/tb.sv
